>>> sv/fmsd_pkg.sv
`default_nettype none
package fmsd_pkg;

    // frame size limit and the widths that follow from it
    localparam int MAX_PIXELS = 1048576;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W      = CNT_W + 16;

    // field widths
    localparam int FLOW_W = 16;
    localparam int EPS_W  = 15;
    localparam int REAL_W = 16;
    localparam int RATE_W = 16;
    localparam int PIX_W  = 13;
    localparam int THR_W  = 31;
    localparam int SPD_W  = 32;
    localparam int DIR_W  = 2;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 3;

    // shared divider: 48-bit dividend covers mean * real * rate
    localparam int PROD_W = 48;
    localparam int DIV_W  = PROD_W;
    localparam int DEN_W  = PIX_W + 8;
    localparam int DVS_W  = (CNT_W > DEN_W) ? CNT_W : DEN_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    // register indexes
    localparam logic [IDX_W-1:0] REG_EPS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_REAL_W = 3'd1;
    localparam logic [IDX_W-1:0] REG_REAL_H = 3'd2;
    localparam logic [IDX_W-1:0] REG_RATE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PIX_W  = 3'd4;
    localparam logic [IDX_W-1:0] REG_PIX_H  = 3'd5;
    localparam logic [IDX_W-1:0] REG_THR_X  = 3'd6;
    localparam logic [IDX_W-1:0] REG_THR_Y  = 3'd7;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
    localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

    // saturation limits
    localparam logic [SPD_W-1:0] SPD_MAX = 32'h7FFF_FFFF;
    localparam logic [SPD_W-1:0] SPD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [EPS_W-1:0]  eps;
        logic [REAL_W-1:0] real_w;
        logic [REAL_W-1:0] real_h;
        logic [RATE_W-1:0] rate;
        logic [PIX_W-1:0]  pix_w;
        logic [PIX_W-1:0]  pix_h;
        logic [THR_W-1:0]  thr_x;
        logic [THR_W-1:0]  thr_y;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] sum_u;
        logic [SUM_W-1:0] sum_v;
        logic [CNT_W-1:0] count_u;
        logic [CNT_W-1:0] count_v;
    } t_frame;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [DIR_W-1:0]  dir_y;
        logic [DIR_W-1:0]  dir_x;
        logic [SPD_W-1:0]  speed_y;
        logic [SPD_W-1:0]  speed_x;
        logic [FLOW_W-1:0] mean_v;
        logic [FLOW_W-1:0] mean_u;
    } t_result;

endpackage
`default_nettype wire

>>> sv/fmsd_accum.sv
`default_nettype none
module fmsd_accum
    import fmsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [FLOW_W-1:0] i_flow_u,
    input  wire logic [FLOW_W-1:0] i_flow_v,
    input  wire logic              i_last,
    input  wire logic [EPS_W-1:0]  i_eps,
    output logic                   o_start,
    output t_frame                 o_frame
);

    logic [SUM_W-1:0] r_sum_u, r_sum_v, n_sum_u, n_sum_v;
    logic [CNT_W-1:0] r_cnt_u, r_cnt_v, n_cnt_u, n_cnt_v;
    logic             r_start;
    t_frame           r_frame;
    logic [FLOW_W:0]  ext_u, ext_v, mag_u, mag_v;
    logic             sig_u, sig_v;

    // significance test on magnitudes, counts stop at the frame limit
    always_comb begin
        ext_u = {i_flow_u[FLOW_W-1], i_flow_u};
        ext_v = {i_flow_v[FLOW_W-1], i_flow_v};
        mag_u = ext_u[FLOW_W] ? ((FLOW_W+1)'(0) - ext_u) : ext_u;
        mag_v = ext_v[FLOW_W] ? ((FLOW_W+1)'(0) - ext_v) : ext_v;
        sig_u = (mag_u > (FLOW_W+1)'(i_eps)) && (r_cnt_u < CNT_W'(MAX_PIXELS));
        sig_v = (mag_v > (FLOW_W+1)'(i_eps)) && (r_cnt_v < CNT_W'(MAX_PIXELS));
        n_sum_u = sig_u ? (r_sum_u + {{(SUM_W-FLOW_W){i_flow_u[FLOW_W-1]}}, i_flow_u})
                        : r_sum_u;
        n_sum_v = sig_v ? (r_sum_v + {{(SUM_W-FLOW_W){i_flow_v[FLOW_W-1]}}, i_flow_v})
                        : r_sum_v;
        n_cnt_u = sig_u ? (r_cnt_u + CNT_W'(1)) : r_cnt_u;
        n_cnt_v = sig_v ? (r_cnt_v + CNT_W'(1)) : r_cnt_v;
    end

    // running sums, frame totals latched and cleared on the last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_u <= '0;
            r_sum_v <= '0;
            r_cnt_u <= '0;
            r_cnt_v <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_accept) begin
                if (i_last) begin
                    r_frame.sum_u   <= n_sum_u;
                    r_frame.sum_v   <= n_sum_v;
                    r_frame.count_u <= n_cnt_u;
                    r_frame.count_v <= n_cnt_v;
                    r_sum_u         <= '0;
                    r_sum_v         <= '0;
                    r_cnt_u         <= '0;
                    r_cnt_v         <= '0;
                    r_start         <= 1'b1;
                end else begin
                    r_sum_u <= n_sum_u;
                    r_sum_v <= n_sum_v;
                    r_cnt_u <= n_cnt_u;
                    r_cnt_v <= n_cnt_v;
                end
            end
        end
    end

    assign o_start = r_start;
    assign o_frame = r_frame;

endmodule
`default_nettype wire

>>> sv/fmsd_div.sv
`default_nettype none
module fmsd_div
    import fmsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              fits;

    // one restoring step: shift in the next dividend bit and trial subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        fits    = (rem_sh >= {1'b0, r_dvs});
    end

    // one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_W);
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem  <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], fits};
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

>>> sv/fmsd_calc.sv
`default_nettype none
module fmsd_calc
    import fmsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_frame   i_frame,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_take,
    output logic          o_busy,
    output logic          o_valid,
    output t_result       o_result,
    output t_div_req      o_div_req,
    input  wire t_div_rsp i_div_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_MUL1,
        S_MUL2,
        S_SPD_GO,
        S_SPD_WAIT,
        S_NEXT,
        S_OUT
    } t_state;

    t_state              r_state;
    logic                r_axis;
    logic [FLOW_W-1:0]   r_mag;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic [SPD_W-1:0]    r_spd;
    t_result             r_res;

    logic [SUM_W-1:0]    sel_sum, sum_mag;
    logic [CNT_W-1:0]    sel_cnt;
    logic [REAL_W-1:0]   sel_real;
    logic [PIX_W-1:0]    sel_pix, pix_eff;
    logic [THR_W-1:0]    sel_thr;
    logic [31:0]         mul_a;
    logic [RATE_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [DIV_W-1:0]    quo;
    logic                quo_big_pos, quo_big_neg;
    logic [SPD_W-1:0]    spd_sat;
    logic [FLOW_W-1:0]   mean_val;
    logic [SPD_W:0]      spd_ext, thr_ext, thr_neg;
    logic [DIR_W-1:0]    dir_val;

    // operand selection for the current axis
    always_comb begin
        sel_sum  = r_axis ? i_frame.sum_v   : i_frame.sum_u;
        sel_cnt  = r_axis ? i_frame.count_v : i_frame.count_u;
        sel_real = r_axis ? i_cfg.real_h    : i_cfg.real_w;
        sel_pix  = r_axis ? i_cfg.pix_h     : i_cfg.pix_w;
        sel_thr  = r_axis ? i_cfg.thr_y     : i_cfg.thr_x;
        sum_mag  = sel_sum[SUM_W-1] ? (SUM_W'(0) - sel_sum) : sel_sum;
        pix_eff  = (sel_pix == '0) ? PIX_W'(1) : sel_pix;
    end

    // shared 32x16 multiplier: |mean| * real, then that product * rate
    always_comb begin
        mul_a = (r_state == S_MUL2) ? r_prod[31:0] : {16'b0, r_mag};
        mul_b = (r_state == S_MUL2) ? i_cfg.rate   : sel_real;
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // divider requests
    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = DIV_W'(sum_mag);
        o_div_req.divisor  = DVS_W'(sel_cnt);
        if (r_state == S_MEAN_GO) begin
            o_div_req.start = (sel_cnt != '0);
        end else if (r_state == S_SPD_GO) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = r_prod;
            o_div_req.divisor  = DVS_W'({pix_eff, 8'b0});
        end
    end

    // saturation of the speed magnitude with its sign applied
    always_comb begin
        quo         = i_div_rsp.quotient;
        quo_big_pos = (quo[DIV_W-1:31] != '0);
        quo_big_neg = (quo[DIV_W-1:32] != '0) || (quo[31] && (quo[30:0] != '0));
        if (r_neg) begin
            spd_sat = quo_big_neg ? SPD_MIN : (SPD_W'(0) - quo[SPD_W-1:0]);
        end else begin
            spd_sat = quo_big_pos ? SPD_MAX : quo[SPD_W-1:0];
        end
    end

    // mean with sign and direction from the saturated speed
    always_comb begin
        mean_val = r_neg ? (FLOW_W'(0) - r_mag) : r_mag;
        spd_ext  = {r_spd[SPD_W-1], r_spd};
        thr_ext  = (SPD_W+1)'(sel_thr);
        thr_neg  = (SPD_W+1)'(0) - thr_ext;
        if ($signed(spd_ext) > $signed(thr_ext)) begin
            dir_val = DIR_POS;
        end else if ($signed(spd_ext) < $signed(thr_neg)) begin
            dir_val = DIR_NEG;
        end else begin
            dir_val = DIR_ZERO;
        end
    end

    // sequencer: mean, two products, speed division, per axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_axis <= 1'b0;
                    if (i_start) begin
                        r_state <= S_MEAN_GO;
                    end
                end
                S_MEAN_GO: begin
                    if (sel_cnt == '0) begin
                        r_mag   <= '0;
                        r_neg   <= 1'b0;
                        r_state <= S_MUL1;
                    end else begin
                        r_state <= S_MEAN_WAIT;
                    end
                end
                S_MEAN_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_mag   <= quo[FLOW_W-1:0];
                        r_neg   <= sel_sum[SUM_W-1];
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= mul_p;
                    r_state <= S_SPD_GO;
                end
                S_SPD_GO: begin
                    r_state <= S_SPD_WAIT;
                end
                S_SPD_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_spd   <= spd_sat;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_axis) begin
                        r_res.mean_v  <= mean_val;
                        r_res.speed_y <= r_spd;
                        r_res.dir_y   <= dir_val;
                        r_state       <= S_OUT;
                    end else begin
                        r_res.mean_u  <= mean_val;
                        r_res.speed_x <= r_spd;
                        r_res.dir_x   <= dir_val;
                        r_axis        <= 1'b1;
                        r_state       <= S_MEAN_GO;
                    end
                end
                S_OUT: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_result = r_res;

endmodule
`default_nettype wire

>>> sv/frame_mean_flow_speed_direction_unit.sv
`default_nettype none
// Frame mean flow speed and direction.
// Input stream: one flow vector per pixel on i_s_tdata, i_s_tlast marks the
// last pixel of a frame. Pixels are taken one per cycle while o_s_tready is
// high; the accumulators add each significant component in the accept cycle.
// The last pixel hands the frame totals to a sequencer that shares one
// restoring divider (48 steps, one quotient bit a cycle, done raised with
// the last bit) and one 32x16 multiplier. Per axis: mean division, two
// products, speed division; an axis with no significant component skips
// its mean division. o_s_tready is low from the cycle after the last pixel
// until the result enters the output register, and o_m_tvalid rises in the
// same cycle as o_s_tready goes high again.
// The result waits in an output register; while it is not taken the next
// frame's pixels still stream in, and the next frame's result waits in the
// sequencer, with the input held off, until the output register frees.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high, only while the block is idle. Reset (synchronous, active low)
// loads register defaults, clears the sums, counts and output valid.
module frame_mean_flow_speed_direction_unit
    import fmsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // flow_u [15:0], flow_v [31:16]
    input  wire logic [31:0]       i_s_tdata,
    input  wire logic              i_s_tlast,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // mean_u [15:0], mean_v [31:16], speed_x [63:32], speed_y [95:64],
    // direction_x [97:96], direction_y [99:98], zero [103:100]
    output logic [103:0]           o_m_tdata
);

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_result  r_out;
    logic     s_accept;
    logic     calc_start;
    logic     calc_busy;
    logic     calc_valid;
    logic     take;
    t_frame   frame;
    t_result  result;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eps    <= EPS_W'(26);
            r_cfg.real_w <= REAL_W'(1000);
            r_cfg.real_h <= REAL_W'(1000);
            r_cfg.rate   <= RATE_W'(7680);
            r_cfg.pix_w  <= PIX_W'(640);
            r_cfg.pix_h  <= PIX_W'(480);
            r_cfg.thr_x  <= '0;
            r_cfg.thr_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_EPS:    r_cfg.eps    <= i_cfg_data[EPS_W-1:0];
                REG_REAL_W: r_cfg.real_w <= i_cfg_data[REAL_W-1:0];
                REG_REAL_H: r_cfg.real_h <= i_cfg_data[REAL_W-1:0];
                REG_RATE:   r_cfg.rate   <= i_cfg_data[RATE_W-1:0];
                REG_PIX_W:  r_cfg.pix_w  <= i_cfg_data[PIX_W-1:0];
                REG_PIX_H:  r_cfg.pix_h  <= i_cfg_data[PIX_W-1:0];
                REG_THR_X:  r_cfg.thr_x  <= i_cfg_data[THR_W-1:0];
                REG_THR_Y:  r_cfg.thr_y  <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input handshake: hold off while a frame is being finished
    assign o_s_tready = !(calc_start || calc_busy);
    assign s_accept   = i_s_tvalid && o_s_tready;

    fmsd_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_flow_u (i_s_tdata[15:0]),
        .i_flow_v (i_s_tdata[31:16]),
        .i_last   (i_s_tlast),
        .i_eps    (r_cfg.eps),
        .o_start  (calc_start),
        .o_frame  (frame)
    );

    fmsd_calc u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (calc_start),
        .i_frame   (frame),
        .i_cfg     (r_cfg),
        .i_take    (take),
        .o_busy    (calc_busy),
        .o_valid   (calc_valid),
        .o_result  (result),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp)
    );

    fmsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // output register
    assign take = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (calc_valid && take) begin
                r_out_valid <= 1'b1;
                r_out       <= result;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out};

    // last pixel stops intake in the following cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> !o_s_tready)
        else $error("intake not stopped after last pixel");

    // a new result only appears after the sequencer has run
    a_result_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(calc_busy))
        else $error("result without a finished frame");

    // horizontal speed is not negative while the horizontal mean is not negative
    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[15]) |-> !o_m_tdata[63])
        else $error("horizontal speed sign differs from mean");

    // nonzero vertical direction needs a nonzero vertical speed
    a_dir_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[99:98] != DIR_ZERO)) |-> (o_m_tdata[95:64] != '0))
        else $error("vertical direction set with zero speed");

endmodule
`default_nettype wire
